/* hdl/assert_macros.svh */
// assertion macros for the rtl folder
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/l2utc_pkg.sv */
// types, constants and calendar step functions for the local to utc converter
// no dependencies
`default_nettype none

package l2utc_pkg;

  localparam int unsigned MinPerDay     = 1440;
  localparam int unsigned MinPerHour    = 60;
  localparam int unsigned YearMax       = 9999;
  localparam int unsigned MonthsPerYear = 12;
  localparam int unsigned LeapFebDays   = 29;
  localparam int unsigned Century       = 100;
  // reciprocal multipliers: exact over the value ranges used
  localparam int unsigned Div100Mul     = 5243;  // y / 100 = (y * 5243) >> 19, y < 16384
  localparam int unsigned Div60Mul      = 2185;  // m / 60 = (m * 2185) >> 17, m < 1440

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_UNDER = 2'd1,
    STATUS_OVER  = 2'd2
  } status_e;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    date_t date;
    logic  fail;
  } step_t;

  typedef struct packed {
    logic       fwd;
    logic [1:0] cnt;
  } roll_t;

  // months outside 1..12 count as 31 days
  function automatic logic [4:0] last_day(input logic leap, input logic [3:0] month);
    logic [4:0] ld;
    unique case (month)
      4'd2:                     ld = leap ? 5'(LeapFebDays) : 5'(LeapFebDays - 1);
      4'd4, 4'd6, 4'd9, 4'd11:  ld = 5'd30;
      default:                  ld = 5'd31;
    endcase
    return ld;
  endfunction

  function automatic step_t day_fwd(input date_t dt, input logic leap);
    step_t r;
    r.date = dt;
    r.fail = 1'b0;
    if (dt.day >= last_day(leap, dt.month)) begin
      if (dt.month >= 4'(MonthsPerYear)) begin
        if (dt.year >= 14'(YearMax)) begin
          r.fail = 1'b1;
        end else begin
          r.date.year  = dt.year + 14'd1;
          r.date.month = 4'd1;
          r.date.day   = 5'd1;
        end
      end else begin
        r.date.month = dt.month + 4'd1;
        r.date.day   = 5'd1;
      end
    end else begin
      r.date.day = dt.day + 5'd1;
    end
    return r;
  endfunction

  // leap only matters inside the same year: a year change lands in december
  function automatic step_t day_back(input date_t dt, input logic leap);
    step_t r;
    r.date = dt;
    r.fail = 1'b0;
    if (dt.day <= 5'd1) begin
      if (dt.month <= 4'd1) begin
        if (dt.year == '0) begin
          r.fail = 1'b1;
        end else begin
          r.date.year  = dt.year - 14'd1;
          r.date.month = 4'(MonthsPerYear);
          r.date.day   = last_day(leap, 4'(MonthsPerYear));
        end
      end else begin
        r.date.month = dt.month - 4'd1;
        r.date.day   = last_day(leap, dt.month - 4'd1);
      end
    end else begin
      r.date.day = dt.day - 5'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/local_to_utc_datetime_top.sv */
// local date/time plus zone offset to utc, four-stage pipeline
// depends on l2utc_pkg and assert_macros.svh
//
// usage:
//  - input channel in_valid_i/in_ready_o carries one request: local date,
//    hour, minute, has_offset_i and a signed offset in minutes
//  - output channel out_valid_o/out_ready_i carries the utc date and time and
//    a status (ok, underflow before year 0, overflow past year 9999)
//  - out_valid_o rises once the request has moved through stages 1, 2 and 3 into
//    the output register of stage 4; one request per cycle when receiver keeps up
//  - stage 1 forms the minute of day and the century quotient, stage 2 the
//    day roll count and the leap flag, stage 3 steps the date up to two days
//    and divides by 60, stage 4 forms the minute and is the output register
//  - each stage holds a valid bit; a stage loads when it is empty or the one
//    after it moves, so a stalled receiver backs the pipe up stage by stage and
//    in_ready_o drops only once all four stages hold a request
//  - reset clears the valid bits; the pipeline comes up empty and ready
//  - without an offset the fields pass through unchanged with status ok
`default_nettype none

`include "assert_macros.svh"

module local_to_utc_datetime_top
  import l2utc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [13:0]        year_i,
  input  wire logic [3:0]         month_i,
  input  wire logic [4:0]         day_i,
  input  wire logic [4:0]         hour_i,
  input  wire logic [5:0]         minute_i,
  input  wire logic               has_offset_i,
  input  wire logic signed [11:0] offset_minutes_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [13:0]        utc_year_o,
  output      logic [3:0]         utc_month_o,
  output      logic [4:0]         utc_day_o,
  output      logic [4:0]         utc_hour_o,
  output      logic [5:0]         utc_minute_o,
  output      logic [1:0]         status_o
);

  localparam logic signed [12:0] OneDay  = 13'(MinPerDay);
  localparam logic signed [12:0] TwoDays = 13'(2 * MinPerDay);

  // handshake / stage enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: minute of day minus offset, year / 100
  logic [10:0]        hm;
  logic signed [12:0] mod1_d;
  logic [26:0]        prod100;
  logic [7:0]         q1_d;

  date_t              date1_q;
  logic               has1_q;
  logic [4:0]         h1_q;
  logic [5:0]         mi1_q;
  logic signed [12:0] mod1_q;
  logic [7:0]         q1_q;

  assign hm      = 11'(hour_i) * 11'(MinPerHour) + 11'(minute_i);
  assign mod1_d  = $signed({2'b00, hm}) - $signed({offset_minutes_i[11], offset_minutes_i});
  assign prod100 = 27'(year_i) * 27'(Div100Mul);
  assign q1_d    = prod100[26:19];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      date1_q <= '{year: year_i, month: month_i, day: day_i};
      has1_q  <= has_offset_i;
      h1_q    <= hour_i;
      mi1_q   <= minute_i;
      mod1_q  <= mod1_d;
      q1_q    <= q1_d;
    end
  end

  // stage 2: roll count, wrapped minute of day, leap flag
  logic [13:0]        rem100;
  logic               leap2_d;
  roll_t              roll2_d;
  logic signed [12:0] wrap2;

  date_t              date2_q;
  logic               has2_q;
  logic [4:0]         h2_q;
  logic [5:0]         mi2_q;
  logic [10:0]        mod2_q;
  roll_t              roll2_q;
  logic               leap2_q;

  assign rem100  = date1_q.year - 14'(15'(q1_q) * 15'(Century));
  assign leap2_d = (date1_q.year[1:0] == 2'b00) && ((rem100 != '0) || (q1_q[1:0] == 2'b00));

  always_comb begin
    roll2_d = '{fwd: 1'b0, cnt: 2'd0};
    wrap2   = mod1_q;
    priority if (mod1_q >= TwoDays) begin
      roll2_d = '{fwd: 1'b1, cnt: 2'd2};
      wrap2   = mod1_q - TwoDays;
    end else if (mod1_q >= OneDay) begin
      roll2_d = '{fwd: 1'b1, cnt: 2'd1};
      wrap2   = mod1_q - OneDay;
    end else if (mod1_q < -OneDay) begin
      roll2_d = '{fwd: 1'b0, cnt: 2'd2};
      wrap2   = mod1_q + TwoDays;
    end else if (mod1_q < 13'sd0) begin
      roll2_d = '{fwd: 1'b0, cnt: 2'd1};
      wrap2   = mod1_q + OneDay;
    end else begin
      roll2_d = '{fwd: 1'b0, cnt: 2'd0};
    end
    // pass-through requests never roll
    if (!has1_q) roll2_d.cnt = 2'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      date2_q <= date1_q;
      has2_q  <= has1_q;
      h2_q    <= h1_q;
      mi2_q   <= mi1_q;
      mod2_q  <= wrap2[10:0];
      roll2_q <= roll2_d;
      leap2_q <= leap2_d;
    end
  end

  // stage 3: up to two day steps, hour = minute of day / 60
  step_t       step_a, step_b;
  date_t       date_mid, date3_d;
  logic        fail3;
  status_e     status3_d;
  logic [22:0] prod60;
  logic [4:0]  h3_d;

  date_t       date3_q;
  status_e     status3_q;
  logic        has3_q;
  logic [4:0]  h3_q;
  logic [5:0]  mi3_q;
  logic [10:0] mod3_q;

  always_comb begin
    step_a   = roll2_q.fwd ? day_fwd(date2_q, leap2_q) : day_back(date2_q, leap2_q);
    date_mid = (roll2_q.cnt != 2'd0) ? step_a.date : date2_q;
    step_b   = roll2_q.fwd ? day_fwd(date_mid, leap2_q) : day_back(date_mid, leap2_q);
    date3_d  = (roll2_q.cnt == 2'd2) ? step_b.date : date_mid;
    fail3    = ((roll2_q.cnt != 2'd0) && step_a.fail) || ((roll2_q.cnt == 2'd2) && step_b.fail);
    if (!fail3) begin
      status3_d = STATUS_OK;
    end else if (roll2_q.fwd) begin
      status3_d = STATUS_OVER;
    end else begin
      status3_d = STATUS_UNDER;
    end
  end

  assign prod60 = 23'(mod2_q) * 23'(Div60Mul);
  assign h3_d   = has2_q ? prod60[21:17] : h2_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      date3_q   <= date3_d;
      status3_q <= status3_d;
      has3_q    <= has2_q;
      h3_q      <= h3_d;
      mi3_q     <= mi2_q;
      mod3_q    <= mod2_q;
    end
  end

  // stage 4: minute = minute of day - hour * 60, output register
  logic [10:0] mi_calc;
  logic [5:0]  mi4_d;

  date_t       date4_q;
  status_e     status4_q;
  logic        has4_q;
  logic [4:0]  h4_q;
  logic [5:0]  mi4_q;

  assign mi_calc = mod3_q - 11'(11'(h3_q) * 11'(MinPerHour));
  assign mi4_d   = has3_q ? mi_calc[5:0] : mi3_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      date4_q   <= date3_q;
      status4_q <= status3_q;
      has4_q    <= has3_q;
      h4_q      <= h3_q;
      mi4_q     <= mi4_d;
    end
  end

  assign out_valid_o  = v4_q;
  assign utc_year_o   = date4_q.year;
  assign utc_month_o  = date4_q.month;
  assign utc_day_o    = date4_q.day;
  assign utc_hour_o   = h4_q;
  assign utc_minute_o = mi4_q;
  assign status_o     = status4_q;

  // assertions
  `ASSERT_IMPL(a_ready_only_when_full, !in_ready_o, v1_q && v2_q && v3_q && v4_q && !out_ready_i, "in_ready_o low with a free stage")
  `ASSERT_IMPL(a_time_in_range, out_valid_o && has4_q, (utc_hour_o <= 5'd23) && (utc_minute_o <= 6'd59), "utc time out of range")
  `ASSERT_IMPL(a_overflow_at_end, out_valid_o && (status_o == STATUS_OVER), (utc_year_o >= 14'(YearMax)) && (utc_month_o >= 4'(MonthsPerYear)), "overflow away from the last month")
  `ASSERT_NEXT(a_output_fills, v3_q && !v4_q, v4_q, "request lost between stage 3 and output")

endmodule

`default_nettype wire
